### rtl/core/dfs_pkg.sv
// ----------------------------------------------------------------------------
// Dissolve fade sequencer package
// Shared codes, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dfs_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_FADE_OUT = 2'd1,
    PH_HOLD     = 2'd2,
    PH_FADE_IN  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_START   = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_CONSUME = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_WB,
    ST_FIN
  } fsm_t;

  localparam logic [1:0] REG_FADE_OUT = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_FADE_IN  = 2'd2;

  localparam int DUR_W = 24;
  localparam int THR_W = 17;
  localparam int Q_W   = 16;
  localparam int CNT_W = 4;
  localparam int DIV_STEPS = 16;

  localparam logic [THR_W-1:0] Q_ONE   = 17'd65536;
  localparam logic [DUR_W-1:0] DUR_MIN = 24'd50000;
  localparam logic [DUR_W-1:0] DUR_MAX = 24'd10000000;

  localparam logic [DUR_W-1:0] RST_FADE_OUT = 24'd800000;
  localparam logic [DUR_W-1:0] RST_HOLD     = 24'd120000;
  localparam logic [DUR_W-1:0] RST_FADE_IN  = 24'd700000;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul1;
    logic mul2;
    logic wb;
    logic out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic need_smooth;
  } dp_sts_t;

endpackage

### rtl/core/dissolve_fade_sequencer_top.sv
// ----------------------------------------------------------------------------
// Dissolve fade sequencer
// Four-phase screen dissolve sequencer: idle, fade out, hold, fade in, with
// a smoothstep threshold and a one-shot switch request.
// ----------------------------------------------------------------------------
//  Channel  Signals                                   Direction
//  in       in_valid, in_ready, cmd, step_us          command in
//  out      out_valid, out_ready, phase, threshold,   result out
//           active, switch_request
//  cfg      cfg_we, cfg_index, cfg_data               register write
//
// A tick in fade out or fade in that stays in its phase runs through the
// 16-step bit-serial progress divider and two multiply stages; every other
// transaction skips them. A new transaction is taken once the
// previous result sits in the output register. A stalled output holds the
// sequencer in its final state. Reset clears the phase, time, threshold and
// switch request and restores the default durations.
// ----------------------------------------------------------------------------
module dissolve_fade_sequencer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic signed [20:0]        step_us,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                phase,
  output logic [16:0]               threshold,
  output logic                      active,
  output logic                      switch_request,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [23:0]               cfg_data
);

  dfs_pkg::dp_ctl_t ctl;
  dfs_pkg::dp_sts_t sts;

  dfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  dfs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .step_us        (step_us),
    .ctl            (ctl),
    .sts            (sts),
    .phase          (phase),
    .threshold      (threshold),
    .active         (active),
    .switch_request (switch_request)
  );

endmodule

### rtl/core/dfs_ctrl.sv
// ----------------------------------------------------------------------------
// Dissolve fade sequencer controller
// Sequences acceptance, the progress division, the smoothstep multiplies
// and the output register load.
// ----------------------------------------------------------------------------
module dfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dfs_pkg::dp_sts_t  sts,
  output dfs_pkg::dp_ctl_t  ctl
);

  localparam logic [dfs_pkg::CNT_W-1:0] DIV_LAST =
    dfs_pkg::CNT_W'(dfs_pkg::DIV_STEPS - 1);

  dfs_pkg::fsm_t state;
  dfs_pkg::fsm_t state_next;
  logic [dfs_pkg::CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dfs_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dfs_pkg::ST_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      dfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = sts.need_smooth ? dfs_pkg::ST_DIV : dfs_pkg::ST_FIN;
        end
      end
      dfs_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = dfs_pkg::ST_MUL1;
        end
      end
      dfs_pkg::ST_MUL1: begin
        ctl.mul1   = 1'b1;
        state_next = dfs_pkg::ST_MUL2;
      end
      dfs_pkg::ST_MUL2: begin
        ctl.mul2   = 1'b1;
        state_next = dfs_pkg::ST_WB;
      end
      dfs_pkg::ST_WB: begin
        ctl.wb     = 1'b1;
        state_next = dfs_pkg::ST_FIN;
      end
      dfs_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = dfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dfs_pkg::ST_IDLE;
      end
    endcase
  end

  a_smooth_enters_div: assert property (@(posedge clk) disable iff (rst)
    ctl.accept && sts.need_smooth |=> state == dfs_pkg::ST_DIV)
    else $error("smoothstep transaction did not start the division");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    state == dfs_pkg::ST_DIV && cnt == DIV_LAST |=> state == dfs_pkg::ST_MUL1)
    else $error("division did not end after its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("output register loaded over a pending result");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |=> !in_ready)
    else $error("second transaction accepted before the first finished");

endmodule

### rtl/core/dfs_datapath.sv
// ----------------------------------------------------------------------------
// Dissolve fade sequencer datapath
// Holds the sequencer state and duration registers, the bit-serial progress
// divider, the smoothstep multiplier chain and the output register.
// ----------------------------------------------------------------------------
module dfs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [dfs_pkg::DUR_W-1:0]         cfg_data,
  input  logic [1:0]                        cmd,
  input  logic signed [20:0]                step_us,
  input  dfs_pkg::dp_ctl_t                  ctl,
  output dfs_pkg::dp_sts_t                  sts,
  output logic [1:0]                        phase,
  output logic [dfs_pkg::THR_W-1:0]         threshold,
  output logic                              active,
  output logic                              switch_request
);

  logic [dfs_pkg::DUR_W-1:0] fade_out_time;
  logic [dfs_pkg::DUR_W-1:0] hold_time;
  logic [dfs_pkg::DUR_W-1:0] fade_in_time;

  dfs_pkg::phase_t           phase_reg;
  logic [31:0]               elapsed;
  logic [dfs_pkg::THR_W-1:0] threshold_reg;
  logic                      switch_pending;

  dfs_pkg::phase_t           phase_next;
  logic [31:0]               elapsed_next;
  logic [dfs_pkg::THR_W-1:0] threshold_next;
  logic                      pending_next;
  logic                      req_next;
  logic                      need_smooth;

  logic [19:0]               step_pos;
  logic [32:0]               sum;
  logic [31:0]               el_tick;
  logic [dfs_pkg::DUR_W-1:0] d_out;
  logic [dfs_pkg::DUR_W-1:0] d_hold;
  logic [dfs_pkg::DUR_W-1:0] d_in;
  logic [dfs_pkg::DUR_W-1:0] d_sel;

  logic [dfs_pkg::DUR_W-1:0] div_d;
  logic [dfs_pkg::DUR_W-1:0] rem;
  logic [dfs_pkg::Q_W-1:0]   quo;
  logic                      fade_in_q;
  logic                      req_reg;
  logic [31:0]               pp;
  logic [49:0]               prod;
  logic [17:0]               fac;
  logic [dfs_pkg::DUR_W:0]   trial;
  logic [49:0]               rnd;
  logic [dfs_pkg::THR_W-1:0] smooth;

  assign step_pos = step_us[20] ? 20'd0 : step_us[19:0];
  assign sum      = {1'b0, elapsed} + {13'd0, step_pos};
  assign el_tick  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign d_out  = (fade_out_time < dfs_pkg::DUR_MIN) ? dfs_pkg::DUR_MIN :
                  (fade_out_time > dfs_pkg::DUR_MAX) ? dfs_pkg::DUR_MAX : fade_out_time;
  assign d_in   = (fade_in_time < dfs_pkg::DUR_MIN) ? dfs_pkg::DUR_MIN :
                  (fade_in_time > dfs_pkg::DUR_MAX) ? dfs_pkg::DUR_MAX : fade_in_time;
  assign d_hold = (hold_time > dfs_pkg::DUR_MAX) ? dfs_pkg::DUR_MAX : hold_time;
  assign d_sel  = (phase_reg == dfs_pkg::PH_FADE_IN) ? d_in : d_out;

  always_comb begin
    phase_next     = phase_reg;
    elapsed_next   = elapsed;
    threshold_next = threshold_reg;
    pending_next   = switch_pending;
    need_smooth    = 1'b0;
    case (cmd)
      dfs_pkg::CMD_TICK: begin
        elapsed_next = el_tick;
        case (phase_reg)
          dfs_pkg::PH_IDLE: begin
            threshold_next = '0;
          end
          dfs_pkg::PH_FADE_OUT: begin
            if (el_tick >= {8'd0, d_out}) begin
              phase_next     = dfs_pkg::PH_HOLD;
              threshold_next = dfs_pkg::Q_ONE;
              elapsed_next   = '0;
              pending_next   = 1'b1;
            end else begin
              need_smooth = 1'b1;
            end
          end
          dfs_pkg::PH_HOLD: begin
            threshold_next = dfs_pkg::Q_ONE;
            if (el_tick >= {8'd0, d_hold}) begin
              phase_next   = dfs_pkg::PH_FADE_IN;
              elapsed_next = '0;
            end
          end
          default: begin
            if (el_tick >= {8'd0, d_in}) begin
              phase_next     = dfs_pkg::PH_IDLE;
              threshold_next = '0;
              elapsed_next   = '0;
            end else begin
              need_smooth = 1'b1;
            end
          end
        endcase
      end
      dfs_pkg::CMD_START: begin
        if (phase_reg == dfs_pkg::PH_IDLE) begin
          phase_next     = dfs_pkg::PH_FADE_OUT;
          threshold_next = '0;
          elapsed_next   = '0;
          pending_next   = 1'b0;
        end
      end
      dfs_pkg::CMD_CANCEL: begin
        phase_next     = dfs_pkg::PH_IDLE;
        threshold_next = '0;
        elapsed_next   = '0;
        pending_next   = 1'b0;
      end
      default: begin
        pending_next = 1'b0;
      end
    endcase
    req_next = (cmd == dfs_pkg::CMD_CONSUME) ? switch_pending : pending_next;
  end

  assign sts.need_smooth = need_smooth;

  assign trial  = {rem, 1'b0};
  assign fac    = 18'd196608 - {1'b0, quo, 1'b0};
  assign rnd    = prod + 50'h0_0000_8000_0000;
  assign smooth = rnd[48:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_out_time  <= dfs_pkg::RST_FADE_OUT;
      hold_time      <= dfs_pkg::RST_HOLD;
      fade_in_time   <= dfs_pkg::RST_FADE_IN;
      phase_reg      <= dfs_pkg::PH_IDLE;
      elapsed        <= '0;
      threshold_reg  <= '0;
      switch_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dfs_pkg::REG_FADE_OUT: fade_out_time <= cfg_data;
          dfs_pkg::REG_HOLD:     hold_time     <= cfg_data;
          dfs_pkg::REG_FADE_IN:  fade_in_time  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (ctl.accept) begin
        phase_reg      <= phase_next;
        elapsed        <= elapsed_next;
        threshold_reg  <= threshold_next;
        switch_pending <= pending_next;
      end
      if (ctl.wb) begin
        threshold_reg <= fade_in_q ? dfs_pkg::Q_ONE - smooth : smooth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      rem       <= el_tick[dfs_pkg::DUR_W-1:0];
      div_d     <= d_sel;
      quo       <= '0;
      fade_in_q <= (phase_reg == dfs_pkg::PH_FADE_IN);
      req_reg   <= req_next;
    end
    if (ctl.div_step) begin
      if (trial >= {1'b0, div_d}) begin
        rem <= dfs_pkg::DUR_W'(trial - {1'b0, div_d});
        quo <= {quo[dfs_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem <= trial[dfs_pkg::DUR_W-1:0];
        quo <= {quo[dfs_pkg::Q_W-2:0], 1'b0};
      end
    end
    if (ctl.mul1) begin
      pp <= {16'd0, quo} * {16'd0, quo};
    end
    if (ctl.mul2) begin
      prod <= {18'd0, pp} * {32'd0, fac};
    end
    if (ctl.out_load) begin
      phase          <= phase_reg;
      threshold      <= threshold_reg;
      active         <= (phase_reg != dfs_pkg::PH_IDLE);
      switch_request <= req_reg;
    end
  end

  a_thr_range: assert property (@(posedge clk) disable iff (rst)
    threshold_reg <= dfs_pkg::Q_ONE)
    else $error("threshold above full scale");

  a_hold_hidden: assert property (@(posedge clk) disable iff (rst)
    phase_reg == dfs_pkg::PH_HOLD |-> threshold_reg == dfs_pkg::Q_ONE)
    else $error("hold phase without full threshold");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase_reg == dfs_pkg::PH_IDLE |-> threshold_reg == '0)
    else $error("idle phase with nonzero threshold");

endmodule

### sim/dissolve_fade_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// Dissolve fade sequencer testbench
// Drives command transactions into the sequencer with random source gaps and
// result-side stalls, predicts every result from its own model of the phases,
// easing curve and switch request, and compares each result field by field.
// Directed cases cover the field extremes, every command, duration clamping
// and idle time accumulation; random rounds follow with new durations each.
// ----------------------------------------------------------------------------
module dissolve_fade_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    dfs_pkg::phase_t ph;
    logic [16:0]     thr;
    logic            act;
    logic            sw;
  } fade_status_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         cmd;
  logic signed [20:0] step_us;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         phase;
  logic [16:0]        threshold;
  logic               active;
  logic               switch_request;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;

  fade_status_t fade_status_q[$];
  int           errors = 0;
  bit           src_gaps_on = 1'b1;
  bit           sink_gaps_on = 1'b1;
  int           sink_stall = 0;

  logic [23:0]     dur_out = dfs_pkg::RST_FADE_OUT;
  logic [23:0]     dur_hold = dfs_pkg::RST_HOLD;
  logic [23:0]     dur_in = dfs_pkg::RST_FADE_IN;
  dfs_pkg::phase_t seq_phase = dfs_pkg::PH_IDLE;
  logic [31:0]     seq_time_us = '0;
  logic [16:0]     seq_thr = '0;
  logic            seq_switch = 1'b0;

  dissolve_fade_sequencer_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .step_us        (step_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .phase          (phase),
    .threshold      (threshold),
    .active         (active),
    .switch_request (switch_request),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] limit_duration(logic [23:0] v, logic [23:0] lo);
    if (v < lo) return {8'b0, lo};
    if (v > dfs_pkg::DUR_MAX) return {8'b0, dfs_pkg::DUR_MAX};
    return {8'b0, v};
  endfunction

  function automatic logic [16:0] fade_fraction(logic [31:0] t, logic [31:0] d);
    logic [63:0] num;
    if (t >= d) return dfs_pkg::Q_ONE;
    num = {32'b0, t} << 16;
    return 17'(num / {32'b0, d});
  endfunction

  // Q1.16 smoothstep 3p^2 - 2p^3, rounded half up.
  function automatic logic [16:0] ease_curve(logic [16:0] p);
    logic [63:0] sq;
    logic [63:0] prod;
    sq = {47'b0, p} * {47'b0, p};
    prod = sq * (64'd196608 - {46'b0, p, 1'b0});
    return 17'((prod + 64'h8000_0000) >> 32);
  endfunction

  function automatic fade_status_t step_sequencer(dfs_pkg::cmd_t c, logic signed [20:0] s);
    fade_status_t res;
    logic [31:0]  adv;
    logic [32:0]  sum;
    logic [31:0]  d;
    case (c)
      dfs_pkg::CMD_TICK: begin
        adv = s[20] ? 32'd0 : {11'b0, s};
        sum = {1'b0, seq_time_us} + {1'b0, adv};
        seq_time_us = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        case (seq_phase)
          dfs_pkg::PH_IDLE: begin
            seq_thr = '0;
          end
          dfs_pkg::PH_FADE_OUT: begin
            d = limit_duration(dur_out, dfs_pkg::DUR_MIN);
            seq_thr = ease_curve(fade_fraction(seq_time_us, d));
            if (seq_time_us >= d) begin
              seq_phase = dfs_pkg::PH_HOLD;
              seq_thr = dfs_pkg::Q_ONE;
              seq_time_us = '0;
              seq_switch = 1'b1;
            end
          end
          dfs_pkg::PH_HOLD: begin
            seq_thr = dfs_pkg::Q_ONE;
            d = limit_duration(dur_hold, 24'd0);
            if (seq_time_us >= d) begin
              seq_phase = dfs_pkg::PH_FADE_IN;
              seq_time_us = '0;
            end
          end
          default: begin
            d = limit_duration(dur_in, dfs_pkg::DUR_MIN);
            seq_thr = dfs_pkg::Q_ONE - ease_curve(fade_fraction(seq_time_us, d));
            if (seq_time_us >= d) begin
              seq_phase = dfs_pkg::PH_IDLE;
              seq_thr = '0;
              seq_time_us = '0;
            end
          end
        endcase
      end
      dfs_pkg::CMD_START: begin
        if (seq_phase == dfs_pkg::PH_IDLE) begin
          seq_phase = dfs_pkg::PH_FADE_OUT;
          seq_thr = '0;
          seq_time_us = '0;
          seq_switch = 1'b0;
        end
      end
      dfs_pkg::CMD_CANCEL: begin
        seq_phase = dfs_pkg::PH_IDLE;
        seq_thr = '0;
        seq_time_us = '0;
        seq_switch = 1'b0;
      end
      default: ;
    endcase
    res.ph = seq_phase;
    res.thr = seq_thr;
    res.act = (seq_phase != dfs_pkg::PH_IDLE);
    res.sw = seq_switch;
    if (c == dfs_pkg::CMD_CONSUME) seq_switch = 1'b0;
    return res;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] pick_duration();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'd0;
    if (r == 1) return 24'($urandom_range(0, 49999));
    if (r == 2) return dfs_pkg::DUR_MIN;
    if (r == 3) return dfs_pkg::DUR_MAX;
    if (r == 4) return 24'($urandom_range(10000001, 16777215));
    if (r < 8) return 24'($urandom_range(50000, 10000000));
    return 24'($urandom_range(50000, 1500000));
  endfunction

  function automatic logic signed [20:0] pick_step();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 21'($urandom_range(0, 2097151));
    if (r == 1) return 21'h100000;
    if (r == 2) return 21'h0FFFFF;
    if (r == 3) return 21'd0;
    return 21'($urandom_range(0, 1048575) >> $urandom_range(0, 8));
  endfunction

  function automatic dfs_pkg::cmd_t pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (seq_phase == dfs_pkg::PH_IDLE) begin
      if (r < 40) return dfs_pkg::CMD_START;
      if (r < 80) return dfs_pkg::CMD_TICK;
      if (r < 90) return dfs_pkg::CMD_CONSUME;
      return dfs_pkg::CMD_CANCEL;
    end
    if (r < 84) return dfs_pkg::CMD_TICK;
    if (r < 92) return dfs_pkg::CMD_CONSUME;
    if (r < 97) return dfs_pkg::CMD_START;
    return dfs_pkg::CMD_CANCEL;
  endfunction

  task automatic send_item(dfs_pkg::cmd_t c, logic signed [20:0] s);
    int gap;
    gap = src_gaps_on ? idle_cycles() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    step_us <= s;
    do begin
      @(posedge clk);
    end while (!in_ready);
    fade_status_q.insert(fade_status_q.size(), step_sequencer(c, s));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (fade_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_durations(logic [23:0] t_out, logic [23:0] t_hold,
                                logic [23:0] t_in);
    cfg_we <= 1'b1;
    cfg_index <= dfs_pkg::REG_FADE_OUT;
    cfg_data <= t_out;
    @(posedge clk);
    cfg_index <= dfs_pkg::REG_HOLD;
    cfg_data <= t_hold;
    @(posedge clk);
    cfg_index <= dfs_pkg::REG_FADE_IN;
    cfg_data <= t_in;
    @(posedge clk);
    cfg_we <= 1'b0;
    dur_out = t_out;
    dur_hold = t_hold;
    dur_in = t_in;
  endtask

  task automatic compare_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (sink_stall > 0) sink_stall--;
      else if (sink_gaps_on) sink_stall = idle_cycles();
      out_ready <= (sink_stall == 0);
    end
  end

  always @(posedge clk) begin : check_results
    fade_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (fade_status_q.size() == 0) begin
        $display("%0t: result with no transaction outstanding, phase %0d threshold %0d",
                 $time, phase, threshold);
        errors++;
      end else begin
        want = fade_status_q.pop_front();
        compare_field("phase", 17'(want.ph), 17'(phase));
        compare_field("threshold", want.thr, threshold);
        compare_field("active", 17'(want.act), 17'(active));
        compare_field("switch_request", 17'(want.sw), 17'(switch_request));
      end
    end
  end

  // One full dissolve at the reset durations, with commands in each phase.
  task automatic test_nominal_cycle();
    send_item(dfs_pkg::CMD_TICK, 21'sd5);
    send_item(dfs_pkg::CMD_CONSUME, 21'h0ABCDE);
    send_item(dfs_pkg::CMD_CANCEL, 21'h155555);
    send_item(dfs_pkg::CMD_START, 21'h1FFFFF);
    send_item(dfs_pkg::CMD_TICK, 21'd0);
    send_item(dfs_pkg::CMD_TICK, 21'd1);
    send_item(dfs_pkg::CMD_TICK, 21'h100000);
    send_item(dfs_pkg::CMD_TICK, 21'd400000);
    send_item(dfs_pkg::CMD_START, 21'h0AAAAA);
    send_item(dfs_pkg::CMD_TICK, 21'h0FFFFF);
    send_item(dfs_pkg::CMD_TICK, 21'd0);
    send_item(dfs_pkg::CMD_CONSUME, 21'd7);
    send_item(dfs_pkg::CMD_CONSUME, 21'd0);
    send_item(dfs_pkg::CMD_TICK, 21'd120000);
    send_item(dfs_pkg::CMD_TICK, 21'd350000);
    send_item(dfs_pkg::CMD_START, 21'd3);
    send_item(dfs_pkg::CMD_TICK, 21'd350000);
    send_item(dfs_pkg::CMD_START, 21'd0);
    send_item(dfs_pkg::CMD_TICK, 21'h0FFFFF);
    send_item(dfs_pkg::CMD_CANCEL, 21'd0);
  endtask

  // Durations below, at and above their limits, including a zero hold.
  task automatic test_duration_limits();
    drain();
    load_durations(24'd0, 24'd0, 24'd0);
    send_item(dfs_pkg::CMD_START, 21'd0);
    send_item(dfs_pkg::CMD_TICK, 21'd49999);
    send_item(dfs_pkg::CMD_TICK, 21'd1);
    send_item(dfs_pkg::CMD_TICK, 21'd0);
    send_item(dfs_pkg::CMD_TICK, 21'd25000);
    send_item(dfs_pkg::CMD_TICK, 21'd25000);
    drain();
    load_durations(24'hFFFFFF, 24'hFFFFFF, dfs_pkg::DUR_MAX);
    send_item(dfs_pkg::CMD_START, 21'd0);
    repeat (10) send_item(dfs_pkg::CMD_TICK, 21'h0FFFFF);
    send_item(dfs_pkg::CMD_CANCEL, 21'd0);
  endtask

  // Idle ticks pile up time; a start must still begin from zero.
  task automatic test_idle_saturation();
    drain();
    load_durations(dfs_pkg::RST_FADE_OUT, dfs_pkg::RST_HOLD, dfs_pkg::RST_FADE_IN);
    src_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    repeat (20) send_item(dfs_pkg::CMD_TICK, 21'h0FFFFF);
    send_item(dfs_pkg::CMD_START, 21'd0);
    send_item(dfs_pkg::CMD_TICK, 21'd1000);
    send_item(dfs_pkg::CMD_CANCEL, 21'd0);
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int rnd = 0; rnd < 8; rnd++) begin
      drain();
      load_durations(pick_duration(), pick_duration(), pick_duration());
      src_gaps_on = (rnd % 4) != 3;
      sink_gaps_on = (rnd % 3) != 2;
      repeat (225) send_item(pick_command(), pick_step());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = dfs_pkg::CMD_TICK;
    step_us = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = dfs_pkg::REG_FADE_OUT;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_nominal_cycle();
    test_duration_limits();
    test_idle_saturation();
    test_random_traffic();
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
